/* sv/sfd_pkg.sv */
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int MAX_STORED = 32;
    localparam int STORE_AW   = (MAX_STORED > 1) ? $clog2(MAX_STORED) : 1;
    localparam int CNT_W      = $clog2(MAX_STORED + 1);
    localparam int IDX_W      = 5;

    localparam logic [7:0]  HEADER_RESET = 8'h4A;
    localparam logic [15:0] SEEN_MAX     = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic start;        // header seen: seed checksum, clear byte count
        logic ld_code_hi;
        logic ld_code_lo;
        logic ld_len_hi;
        logic ld_len_lo;
        logic ld_payload;   // store byte (first MAX_STORED only), count it, fold into checksum
        logic idx_clr;
        logic idx_inc;
        logic rd_store;
        logic out_ld_single;
        logic out_ok;
        logic out_ld_store;
    } sfd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hdr_match;
        logic len_zero_next;
        logic payload_done;
        logic xor_match;
        logic len_zero;
        logic last_idx;
        logic out_free;
    } sfd_status_t;

endpackage

/* sv/sfd_datapath.sv */
`timescale 1ns / 1ps

module sfd_datapath
    import sfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic [7:0]          rx_byte,
    input  sfd_cmd_t            cmd,
    output sfd_status_t         status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [15:0]         function_code,
    output logic [15:0]         frame_length,
    output logic                checksum_ok,
    output logic                has_payload,
    output logic [IDX_W-1:0]    byte_index,
    output logic [7:0]          payload_byte,
    output logic                last
);

    logic [7:0]          frame_header_reg;
    logic [15:0]         code_reg;
    logic [15:0]         length_reg;
    logic [15:0]         bytes_seen_reg;
    logic [15:0]         bytes_seen_next;
    logic [7:0]          xor_reg;
    logic [STORE_AW-1:0] rd_idx_reg;
    logic [7:0]          rd_data_reg;
    logic [7:0]          store_mem [MAX_STORED];
    logic [CNT_W-1:0]    run_cnt;
    logic                store_wr;

    logic                out_valid_reg;
    logic [15:0]         out_code_reg;
    logic [15:0]         out_len_reg;
    logic                out_ok_reg;
    logic                out_has_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;

    assign bytes_seen_next = (bytes_seen_reg != SEEN_MAX) ? bytes_seen_reg + 16'd1
                                                           : bytes_seen_reg;
    assign store_wr = cmd.ld_payload && (bytes_seen_reg < 16'(MAX_STORED));
    assign run_cnt  = (length_reg < 16'(MAX_STORED)) ? length_reg[CNT_W-1:0]
                                                      : CNT_W'(MAX_STORED);

    assign status.hdr_match     = (rx_byte == frame_header_reg);
    assign status.len_zero_next = ({length_reg[15:8], rx_byte} == 16'd0);
    assign status.payload_done  = (bytes_seen_next >= length_reg);
    assign status.xor_match     = (xor_reg == rx_byte);
    assign status.len_zero      = (length_reg == 16'd0);
    assign status.last_idx      = ({1'b0, rd_idx_reg} + CNT_W'(1)) == run_cnt;
    assign status.out_free      = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_header_reg <= HEADER_RESET;
            code_reg         <= '0;
            length_reg       <= '0;
            bytes_seen_reg   <= '0;
            xor_reg          <= '0;
            rd_idx_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                frame_header_reg <= cfg_wr_data;

            if (cmd.start)
            begin
                xor_reg        <= rx_byte;
                bytes_seen_reg <= '0;
            end
            else if (cmd.ld_code_hi || cmd.ld_code_lo || cmd.ld_len_hi ||
                     cmd.ld_len_lo || cmd.ld_payload)
                xor_reg <= xor_reg ^ rx_byte;

            if (cmd.ld_code_hi)
                code_reg <= {rx_byte, 8'd0};
            if (cmd.ld_code_lo)
                code_reg <= {code_reg[15:8], rx_byte};
            if (cmd.ld_len_hi)
                length_reg <= {rx_byte, 8'd0};
            if (cmd.ld_len_lo)
                length_reg <= {length_reg[15:8], rx_byte};
            if (cmd.ld_payload)
                bytes_seen_reg <= bytes_seen_next;

            if (cmd.idx_clr)
                rd_idx_reg <= '0;
            else if (cmd.idx_inc)
                rd_idx_reg <= rd_idx_reg + STORE_AW'(1);

            if (cmd.out_ld_single || cmd.out_ld_store)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (store_wr)
            store_mem[bytes_seen_reg[STORE_AW-1:0]] <= rx_byte;
        if (cmd.rd_store)
            rd_data_reg <= store_mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld_single)
        begin
            out_code_reg <= code_reg;
            out_len_reg  <= length_reg;
            out_ok_reg   <= cmd.out_ok;
            out_has_reg  <= 1'b0;
            out_idx_reg  <= '0;
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.out_ld_store)
        begin
            out_code_reg <= code_reg;
            out_len_reg  <= length_reg;
            out_ok_reg   <= 1'b1;
            out_has_reg  <= 1'b1;
            out_idx_reg  <= IDX_W'(rd_idx_reg);
            out_byte_reg <= rd_data_reg;
            out_last_reg <= status.last_idx;
        end
    end

    assign out_valid     = out_valid_reg;
    assign function_code = out_code_reg;
    assign frame_length  = out_len_reg;
    assign checksum_ok   = out_ok_reg;
    assign has_payload   = out_has_reg;
    assign byte_index    = out_idx_reg;
    assign payload_byte  = out_byte_reg;
    assign last          = out_last_reg;

endmodule

/* sv/sfd_ctrl.sv */
`timescale 1ns / 1ps

module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sfd_status_t status,
    output sfd_cmd_t    cmd
);

    localparam logic [3:0] ST_WAIT    = 4'd0;
    localparam logic [3:0] ST_CODE_HI = 4'd1;
    localparam logic [3:0] ST_CODE_LO = 4'd2;
    localparam logic [3:0] ST_LEN_HI  = 4'd3;
    localparam logic [3:0] ST_LEN_LO  = 4'd4;
    localparam logic [3:0] ST_PAYLOAD = 4'd5;
    localparam logic [3:0] ST_CHECK   = 4'd6;
    localparam logic [3:0] ST_EMIT_RD = 4'd7;
    localparam logic [3:0] ST_EMIT_LD = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    // checksum byte needs a free output slot, whatever result follows
    assign in_ready = !(state_reg inside {ST_EMIT_RD, ST_EMIT_LD}) &&
                      ((state_reg != ST_CHECK) || status.out_free);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_WAIT:
            begin
                if (accept && status.hdr_match)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CODE_HI;
                end
            end
            ST_CODE_HI:
            begin
                if (accept)
                begin
                    cmd.ld_code_hi = 1'b1;
                    state_next     = ST_CODE_LO;
                end
            end
            ST_CODE_LO:
            begin
                if (accept)
                begin
                    cmd.ld_code_lo = 1'b1;
                    state_next     = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (accept)
                begin
                    cmd.ld_len_hi = 1'b1;
                    state_next    = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (accept)
                begin
                    cmd.ld_len_lo = 1'b1;
                    state_next    = status.len_zero_next ? ST_CHECK : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (accept)
                begin
                    cmd.ld_payload = 1'b1;
                    if (status.payload_done)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (accept)
                begin
                    if (!status.xor_match)
                    begin
                        cmd.out_ld_single = 1'b1;
                        state_next        = ST_WAIT;
                    end
                    else if (status.len_zero)
                    begin
                        cmd.out_ld_single = 1'b1;
                        cmd.out_ok        = 1'b1;
                        state_next        = ST_WAIT;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd_store = 1'b1;
                state_next   = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_ld_store = 1'b1;
                    if (status.last_idx)
                        state_next = ST_WAIT;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/serial_frame_decoder_xor_checksum.sv */
`timescale 1ns / 1ps
// one received byte per cycle is taken while a frame is parsed (header, code, length, payload)
// a bad checksum or empty frame gives its single result the cycle after the checksum byte
// a good frame streams its stored bytes, each by a store read and then an output load,
// the load waiting for a free output slot; input is held off meanwhile
// reset is asynchronous: parser returns to header hunt, header register to 0x4a,
// payload store contents are left undefined
module serial_frame_decoder_xor_checksum
    import sfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      function_code,
    output logic [15:0]      frame_length,
    output logic             checksum_ok,
    output logic             has_payload,
    output logic [IDX_W-1:0] byte_index,
    output logic [7:0]       payload_byte,
    output logic             last
);

    sfd_cmd_t    cmd;
    sfd_status_t status;

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .function_code (function_code),
        .frame_length  (frame_length),
        .checksum_ok   (checksum_ok),
        .has_payload   (has_payload),
        .byte_index    (byte_index),
        .payload_byte  (payload_byte),
        .last          (last)
    );

    // only one source may load the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.out_ld_single, cmd.out_ld_store}))
        else $error("output register loaded from two sources");

    // no item is taken while stored bytes stream out
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld_store || cmd.rd_store) |-> !in_ready)
        else $error("input accepted during payload run");

    // a result without payload closes its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_payload) |-> last)
        else $error("payload-less result not marked last");

    // a failed checksum never carries payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !checksum_ok) |->
            (!has_payload && byte_index == '0 && payload_byte == 8'd0))
        else $error("bad-checksum result carries payload");

endmodule
